// ----- rtl/vbap_gain_set_select_defines.svh -----
// Assertion helpers for the panning gain selector.
`ifndef VBAP_GAIN_SET_SELECT_DEFINES_SVH
`define VBAP_GAIN_SET_SELECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VGS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define VGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VGS_ASSERT_NOW(label, ante, cons, msg)
`define VGS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/vgs_pkg.sv -----
`timescale 1ns / 1ps
package vgs_pkg;
   localparam int MAX_SETS_DEF     = 64;
   localparam int MAX_SPEAKERS_DEF = 256;
   localparam int GAIN_W           = 27;
   localparam int PROD_W           = 40;
   localparam logic OP_LOAD        = 1'b0;
   localparam logic OP_DIR         = 1'b1;
   localparam logic CSR_DIMENSION  = 1'b0;
   localparam logic CSR_SETS       = 1'b1;
   localparam logic [3:0] ENT_MAT_LAST = 4'd8;
   localparam logic [3:0] ENT_SPK_A    = 4'd9;
   localparam logic [1:0] DIM_PAIR     = 2'd2;
   localparam logic signed [GAIN_W-1:0] NEG_LIMIT = -27'sd3277;
   localparam logic [22:0] GAIN_ONE = 23'd65536;
   localparam logic [22:0] GAIN_MAX = 23'd8388607;

   typedef logic signed [GAIN_W-1:0] gain_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic first;
      logic dim3;
   } tag_type;

   function automatic logic [22:0] clamp_gain(input gain_type g);
      logic [22:0] r;
      if (g < 0) r = '0;
      else if (g > $signed({4'd0, GAIN_MAX})) r = GAIN_MAX;
      else r = g[22:0];
      return r;
   endfunction
endpackage

// ----- rtl/vgs_req_if.sv -----
`timescale 1ns / 1ps
interface vgs_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [5:0]         set_index;
   logic [3:0]         entry_index;
   logic signed [23:0] entry_value;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   modport source (output valid, op, set_index, entry_index, entry_value, dir_x, dir_y,
                   dir_z, input ready);
   modport sink (input valid, op, set_index, entry_index, entry_value, dir_x, dir_y,
                 dir_z, output ready);
endinterface

// ----- rtl/vgs_rsp_if.sv -----
`timescale 1ns / 1ps
interface vgs_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  chosen_set;
   logic [7:0]  speaker_a;
   logic [7:0]  speaker_b;
   logic [7:0]  speaker_c;
   logic [22:0] gain_a;
   logic [22:0] gain_b;
   logic [22:0] gain_c;
   logic [1:0]  negative_count;
   logic        fallback_used;
   modport source (output valid, chosen_set, speaker_a, speaker_b, speaker_c, gain_a,
                   gain_b, gain_c, negative_count, fallback_used, input ready);
   modport sink (input valid, chosen_set, speaker_a, speaker_b, speaker_c, gain_a,
                 gain_b, gain_c, negative_count, fallback_used, output ready);
endinterface

// ----- rtl/vgs_ram.sv -----
`timescale 1ns / 1ps
module vgs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/vgs_row_cell.sv -----
`timescale 1ns / 1ps
// one gain row: three products, then sum and floor shift
module vgs_row_cell (
   input  logic                  clock,
   input  logic                  active,
   input  logic signed [15:0]    dir_x,
   input  logic signed [15:0]    dir_y,
   input  logic signed [15:0]    dir_z,
   input  logic signed [23:0]    m0,
   input  logic signed [23:0]    m1,
   input  logic signed [23:0]    m2,
   output vgs_pkg::gain_type     gain
);
   logic signed [vgs_pkg::PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic                              active_ff;
   logic signed [vgs_pkg::PROD_W+1:0] sum_in;
   vgs_pkg::gain_type                 gain_ff;

   assign sum_in = 42'(p0_ff) + 42'(p1_ff) + 42'(p2_ff);

   always_ff @(posedge clock) begin
      p0_ff     <= dir_x * m0;
      p1_ff     <= dir_y * m1;
      p2_ff     <= dir_z * m2;
      active_ff <= active;
      gain_ff   <= active_ff ? vgs_pkg::gain_type'(sum_in >>> 15) : '0;
   end
   assign gain = gain_ff;
endmodule

// ----- rtl/vgs_select.sv -----
`timescale 1ns / 1ps
// keeps the best set seen so far in the walk
module vgs_select #(
   parameter int IW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  vgs_pkg::tag_type  tag,
   input  logic [IW-1:0]     idx,
   input  vgs_pkg::gain_type g0,
   input  vgs_pkg::gain_type g1,
   input  vgs_pkg::gain_type g2,
   output logic [IW-1:0]     best_idx,
   output vgs_pkg::gain_type best_g0,
   output vgs_pkg::gain_type best_g1,
   output vgs_pkg::gain_type best_g2,
   output logic [1:0]        best_neg
);
   vgs_pkg::gain_type small_in, best_small_ff;
   vgs_pkg::gain_type bg0_ff, bg1_ff, bg2_ff;
   logic [IW-1:0]     best_idx_ff;
   logic [1:0]        neg_in, best_neg_ff;
   logic              take;

   always_comb begin
      small_in = (g1 < g0) ? g1 : g0;
      if (tag.dim3 && g2 < small_in) small_in = g2;
      neg_in = 2'(g0 <= vgs_pkg::NEG_LIMIT) + 2'(g1 <= vgs_pkg::NEG_LIMIT)
             + 2'(tag.dim3 && g2 <= vgs_pkg::NEG_LIMIT);
      take = tag.first || neg_in < best_neg_ff
           || (neg_in == best_neg_ff && small_in > best_small_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_idx_ff <= '0;
         best_neg_ff <= '0;
      end else if (tag.valid && take) begin
         best_idx_ff <= idx;
         best_neg_ff <= neg_in;
      end
      if (tag.valid && take) begin
         best_small_ff <= small_in;
         bg0_ff        <= g0;
         bg1_ff        <= g1;
         bg2_ff        <= g2;
      end
   end

   assign best_idx = best_idx_ff;
   assign best_neg = best_neg_ff;
   assign best_g0  = bg0_ff;
   assign best_g1  = bg1_ff;
   assign best_g2  = bg2_ff;
endmodule

// ----- rtl/vbap_gain_set_select.sv -----
`timescale 1ns / 1ps
// Panning gain selector.
// req channel carries words of two kinds: a load word writes one matrix element
// (entry 0-8) or speaker number (entry 9-11) of a speaker set.
// A direction word walks sets 0..N-1, one set per cycle through a row of
// three gain cells (multiply stage, sum stage) and a compare stage; then the
// speaker numbers of the winner are read. N is sets_in_use clamped to 1..MAX_SETS.
// A direction walks the matrix memory one set per cycle and its result is then
// written to the output register; req is ready only between directions, so a new
// word is not accepted until the previous direction has reached that register.
// rsp carries one word per direction, held in an output register; while rsp is
// stalled a new load or direction can still be accepted, and a finished direction
// waits until the register frees, holding req not ready meanwhile.
// csr port: index 0 dimension, index 1 sets_in_use; write only while idle.
// Reset returns to idle, dimension 3, one set in use; the tables are undefined
// until loaded.
`include "vbap_gain_set_select_defines.svh"
module vbap_gain_set_select #(
   parameter int MAX_SETS     = vgs_pkg::MAX_SETS_DEF,
   parameter int MAX_SPEAKERS = vgs_pkg::MAX_SPEAKERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vgs_req_if.sink     req,
   vgs_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [6:0]  csr_write_data
);
   localparam int IW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam logic [7:0] SPK_TOP = 8'(MAX_SPEAKERS - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_WAIT, ST_RD, ST_OUT} state_type;

   state_type state_ff;
   logic [1:0] dimension_ff;
   logic [6:0] sets_ff;
   logic [IW-1:0] idx_ff;
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   vgs_pkg::tag_type tag0_ff, tag1_ff, tag2_ff, tag0_in;
   logic [IW-1:0] idx0_ff, idx1_ff, idx2_ff;
   logic dim3;
   logic [10:0] count, last_idx;
   logic accept, load_ok;
   logic [23:0] mat_rd [9];
   logic [7:0]  spk_rd [3];
   logic [7:0]  spk_wr;
   logic signed [23:0] cm [3][3];
   vgs_pkg::gain_type g [3];
   vgs_pkg::gain_type bg0, bg1, bg2;
   logic [IW-1:0] best_idx;
   logic [1:0] best_neg;
   logic fallback;
   logic out_free;

   logic rsp_valid_ff, rsp_valid_in;
   logic [5:0] chosen_ff;
   logic [7:0] spk_a_ff, spk_b_ff, spk_c_ff;
   logic [22:0] gain_a_ff, gain_b_ff, gain_c_ff;
   logic [1:0] neg_ff;
   logic fallback_ff;

   assign dim3   = (dimension_ff != vgs_pkg::DIM_PAIR);
   assign accept = req.valid && req.ready;
   assign load_ok = accept && req.op == vgs_pkg::OP_LOAD
                  && {5'd0, req.set_index} < 11'(MAX_SETS);
   assign spk_wr = (req.entry_value[7:0] > SPK_TOP) ? SPK_TOP : req.entry_value[7:0];

   always_comb begin
      count = (sets_ff == '0) ? 11'd1 : {4'd0, sets_ff};
      if (count > 11'(MAX_SETS)) count = 11'(MAX_SETS);
      last_idx = count - 11'd1;
   end

   for (genvar e = 0; e < 9; e++) begin : g_mat
      vgs_ram #(.WIDTH(24), .DEPTH(MAX_SETS)) u_mat (
         .clock   (clock),
         .wr_en   (load_ok && req.entry_index == 4'(e)),
         .wr_addr (IW'(req.set_index)),
         .wr_data (req.entry_value),
         .rd_addr (idx_ff),
         .rd_data (mat_rd[e])
      );
   end

   for (genvar s = 0; s < 3; s++) begin : g_spk
      vgs_ram #(.WIDTH(8), .DEPTH(MAX_SETS)) u_spk (
         .clock   (clock),
         .wr_en   (load_ok && req.entry_index == vgs_pkg::ENT_SPK_A + 4'(s)),
         .wr_addr (IW'(req.set_index)),
         .wr_data (spk_wr),
         .rd_addr (best_idx),
         .rd_data (spk_rd[s])
      );
   end

   // element selection per row: 3x3 row-major, or 2x2 packed in entries 0-3
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            cm[j][k] = '0;
         end
      end
      if (tag0_ff.dim3) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               cm[j][k] = $signed(mat_rd[3*j+k]);
            end
         end
      end else begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               cm[j][k] = $signed(mat_rd[2*j+k]);
            end
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_cell
      vgs_row_cell u_cell (
         .clock  (clock),
         .active (j < 2 || tag0_ff.dim3),
         .dir_x  (dx_ff),
         .dir_y  (dy_ff),
         .dir_z  (dz_ff),
         .m0     (cm[j][0]),
         .m1     (cm[j][1]),
         .m2     (cm[j][2]),
         .gain   (g[j])
      );
   end

   vgs_select #(.IW(IW)) u_select (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag2_ff),
      .idx      (idx2_ff),
      .g0       (g[0]),
      .g1       (g[1]),
      .g2       (g[2]),
      .best_idx (best_idx),
      .best_g0  (bg0),
      .best_g1  (bg1),
      .best_g2  (bg2),
      .best_neg (best_neg)
   );

   always_comb begin
      tag0_in.valid = (state_ff == ST_WALK);
      tag0_in.last  = ({{(11-IW){1'b0}}, idx_ff} == last_idx);
      tag0_in.first = (idx_ff == '0);
      tag0_in.dim3  = dim3;
   end

   assign fallback = bg0 <= 0 && bg1 <= 0 && (bg2 <= 0 || !dim3);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = (state_ff == ST_OUT && out_free) ? 1'b1
                       : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dimension_ff <= 2'd3;
         sets_ff      <= 7'd1;
         idx_ff       <= '0;
         tag0_ff      <= '0;
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               vgs_pkg::CSR_DIMENSION: dimension_ff <= csr_write_data[1:0];
               vgs_pkg::CSR_SETS:      sets_ff      <= csr_write_data;
               default:                ;
            endcase
         end
         tag0_ff <= tag0_in;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept && req.op == vgs_pkg::OP_DIR) state_ff <= ST_WALK;
            end
            ST_WALK: begin
               idx_ff <= idx_ff + 1'b1;
               if (tag0_in.last) state_ff <= ST_WAIT;
            end
            ST_WAIT: if (tag2_ff.valid && tag2_ff.last) state_ff <= ST_RD;
            ST_RD:   state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (accept) begin
         dx_ff <= req.dir_x;
         dy_ff <= req.dir_y;
         dz_ff <= dim3 ? req.dir_z : '0;
      end
      idx0_ff <= idx_ff;
      idx1_ff <= idx0_ff;
      idx2_ff <= idx1_ff;
      if (state_ff == ST_OUT && out_free) begin
         chosen_ff   <= 6'(best_idx);
         spk_a_ff    <= spk_rd[0];
         spk_b_ff    <= spk_rd[1];
         spk_c_ff    <= dim3 ? spk_rd[2] : '0;
         gain_a_ff   <= fallback ? vgs_pkg::GAIN_ONE : vgs_pkg::clamp_gain(bg0);
         gain_b_ff   <= fallback ? vgs_pkg::GAIN_ONE : vgs_pkg::clamp_gain(bg1);
         gain_c_ff   <= !dim3 ? '0 :
                        (fallback ? vgs_pkg::GAIN_ONE : vgs_pkg::clamp_gain(bg2));
         neg_ff      <= best_neg;
         fallback_ff <= fallback;
      end
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.chosen_set     = chosen_ff;
   assign rsp.speaker_a      = spk_a_ff;
   assign rsp.speaker_b      = spk_b_ff;
   assign rsp.speaker_c      = spk_c_ff;
   assign rsp.gain_a         = gain_a_ff;
   assign rsp.gain_b         = gain_b_ff;
   assign rsp.gain_c         = gain_c_ff;
   assign rsp.negative_count = neg_ff;
   assign rsp.fallback_used  = fallback_ff;

   `VGS_ASSERT_NEXT(a_dir_starts_walk, accept && req.op == vgs_pkg::OP_DIR,
      state_ff == ST_WALK, "direction word did not start the walk")
   `VGS_ASSERT_NEXT(a_last_reads_spk, state_ff == ST_WAIT && tag2_ff.valid && tag2_ff.last,
      state_ff == ST_RD, "walk end not followed by speaker read")
   `VGS_ASSERT_NEXT(a_first_set_taken, tag2_ff.valid && tag2_ff.first,
      best_idx == '0, "first set not taken as initial best")
endmodule
